// ----- rtl/core/ecpa_pkg.sv -----
// shared types, constants and microcode for the secp256k1 point engine
package ecpa_pkg;

  localparam int unsigned FE_BITS = 256;
  localparam logic [FE_BITS-1:0] PRIME =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;

  typedef logic [FE_BITS-1:0] fe_t;
  typedef logic [4:0] reg_addr_t;
  typedef logic [4:0] ow_addr_t;
  typedef logic [5:0] pc_t;

  localparam logic [1:0] COORD_X = 2'd0;
  localparam logic [1:0] COORD_Y = 2'd1;
  localparam logic [1:0] COORD_Z = 2'd2;
  localparam logic [1:0] WORD_LAST = 2'd3;
  localparam ow_addr_t POINT2_BASE = 5'd12;

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_CMPV, OP_CMPU, OP_BRANCH, OP_END
  } op_e;

  typedef enum logic [1:0] {WB_ALU, WB_MUL, WB_LOAD} wb_sel_e;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_MUL, S_LOAD, S_OUTRD, S_OUTLD, S_OUT
  } state_e;

  typedef struct packed {
    op_e       op;
    reg_addr_t dst;
    reg_addr_t src_a;
    reg_addr_t src_b;
  } instr_t;

  typedef struct packed {
    logic      in_we;
    ow_addr_t  in_addr;
    logic      rf_rd;
    reg_addr_t ra;
    reg_addr_t rb;
    logic      ow_rd;
    ow_addr_t  ow_addr;
    logic      ld_shift;
    op_e       alu_op;
    logic      mul_start;
    logic      wb_en;
    wb_sel_e   wb_sel;
    reg_addr_t wb_dst;
    logic      cmpv_en;
    logic      cmpu_en;
    logic      out_load;
    logic      out_zero;
    logic      out_shift;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic eq_v;
    logic eq_u;
  } sts_t;

  // register file map
  localparam reg_addr_t R_X1 = 5'd0;
  localparam reg_addr_t R_Y1 = 5'd1;
  localparam reg_addr_t R_Z1 = 5'd2;
  localparam reg_addr_t R_X2 = 5'd3;
  localparam reg_addr_t R_Y2 = 5'd4;
  localparam reg_addr_t R_Z2 = 5'd5;
  localparam reg_addr_t R_RX = 5'd6;
  localparam reg_addr_t R_RY = 5'd7;
  localparam reg_addr_t R_RZ = 5'd8;
  localparam reg_addr_t R_W = 5'd9;
  localparam reg_addr_t R_S = 5'd10;
  localparam reg_addr_t R_B = 5'd11;
  localparam reg_addr_t R_H = 5'd12;
  localparam reg_addr_t R_B8 = 5'd13;
  localparam reg_addr_t R_S2 = 5'd14;
  localparam reg_addr_t R_YY = 5'd15;
  localparam reg_addr_t R_T = 5'd16;
  localparam reg_addr_t R_U1 = 5'd17;
  localparam reg_addr_t R_U2 = 5'd18;
  localparam reg_addr_t R_V1 = 5'd19;
  localparam reg_addr_t R_V2 = 5'd20;
  localparam reg_addr_t R_U = 5'd21;
  localparam reg_addr_t R_V = 5'd22;
  localparam reg_addr_t R_WW = 5'd23;
  localparam reg_addr_t R_US2W = 5'd24;
  localparam reg_addr_t R_VS2 = 5'd25;
  localparam reg_addr_t R_VS3 = 5'd26;
  localparam reg_addr_t R_VS2V2 = 5'd27;
  localparam reg_addr_t R_A = 5'd28;

  localparam pc_t PC_LAST_LOAD = 6'd5;
  localparam pc_t PC_ADD = 6'd6;
  localparam pc_t PC_DBL = 6'd31;

  function automatic instr_t mk(op_e op, reg_addr_t d, reg_addr_t a, reg_addr_t b);
    instr_t r;
    r.op = op;
    r.dst = d;
    r.src_a = a;
    r.src_b = b;
    return r;
  endfunction

  // microcode: loads, addition, doubling
  function automatic instr_t prog_rom(pc_t pc);
    instr_t r;
    unique case (pc)
      6'd0:  r = mk(OP_LOAD, R_X1, 5'd0, 5'd0);
      6'd1:  r = mk(OP_LOAD, R_Y1, 5'd1, 5'd0);
      6'd2:  r = mk(OP_LOAD, R_Z1, 5'd2, 5'd0);
      6'd3:  r = mk(OP_LOAD, R_X2, 5'd3, 5'd0);
      6'd4:  r = mk(OP_LOAD, R_Y2, 5'd4, 5'd0);
      6'd5:  r = mk(OP_LOAD, R_Z2, 5'd5, 5'd0);
      6'd6:  r = mk(OP_MUL, R_U1, R_Y2, R_Z1);
      6'd7:  r = mk(OP_MUL, R_U2, R_Y1, R_Z2);
      6'd8:  r = mk(OP_SUB, R_U, R_U1, R_U2);
      6'd9:  r = mk(OP_MUL, R_V1, R_X2, R_Z1);
      6'd10: r = mk(OP_MUL, R_V2, R_X1, R_Z2);
      6'd11: r = mk(OP_SUB, R_V, R_V1, R_V2);
      6'd12: r = mk(OP_MUL, R_WW, R_Z1, R_Z2);
      6'd13: r = mk(OP_CMPV, R_V1, R_V1, R_V2);
      6'd14: r = mk(OP_CMPU, R_U1, R_U1, R_U2);
      6'd15: r = mk(OP_BRANCH, R_X1, R_X1, R_X1);
      6'd16: r = mk(OP_MUL, R_US2W, R_U, R_U);
      6'd17: r = mk(OP_MUL, R_US2W, R_US2W, R_WW);
      6'd18: r = mk(OP_MUL, R_VS2, R_V, R_V);
      6'd19: r = mk(OP_MUL, R_VS3, R_VS2, R_V);
      6'd20: r = mk(OP_MUL, R_VS2V2, R_VS2, R_V2);
      6'd21: r = mk(OP_SUB, R_A, R_US2W, R_VS3);
      6'd22: r = mk(OP_SUB, R_A, R_A, R_VS2V2);
      6'd23: r = mk(OP_SUB, R_A, R_A, R_VS2V2);
      6'd24: r = mk(OP_MUL, R_RX, R_V, R_A);
      6'd25: r = mk(OP_MUL, R_RZ, R_VS3, R_WW);
      6'd26: r = mk(OP_MUL, R_VS3, R_VS3, R_U2);
      6'd27: r = mk(OP_SUB, R_RY, R_VS2V2, R_A);
      6'd28: r = mk(OP_MUL, R_RY, R_RY, R_U);
      6'd29: r = mk(OP_SUB, R_RY, R_RY, R_VS3);
      6'd30: r = mk(OP_END, R_X1, R_X1, R_X1);
      6'd31: r = mk(OP_MUL, R_T, R_X1, R_X1);
      6'd32: r = mk(OP_ADD, R_W, R_T, R_T);
      6'd33: r = mk(OP_ADD, R_W, R_W, R_T);
      6'd34: r = mk(OP_MUL, R_S, R_Y1, R_Z1);
      6'd35: r = mk(OP_MUL, R_B, R_Y1, R_S);
      6'd36: r = mk(OP_MUL, R_B, R_B, R_X1);
      6'd37: r = mk(OP_MUL, R_H, R_W, R_W);
      6'd38: r = mk(OP_ADD, R_B8, R_B, R_B);
      6'd39: r = mk(OP_ADD, R_B8, R_B8, R_B8);
      6'd40: r = mk(OP_ADD, R_B8, R_B8, R_B8);
      6'd41: r = mk(OP_SUB, R_H, R_H, R_B8);
      6'd42: r = mk(OP_MUL, R_RX, R_H, R_S);
      6'd43: r = mk(OP_ADD, R_RX, R_RX, R_RX);
      6'd44: r = mk(OP_MUL, R_S2, R_S, R_S);
      6'd45: r = mk(OP_MUL, R_YY, R_Y1, R_Y1);
      6'd46: r = mk(OP_MUL, R_T, R_YY, R_S2);
      6'd47: r = mk(OP_ADD, R_T, R_T, R_T);
      6'd48: r = mk(OP_ADD, R_T, R_T, R_T);
      6'd49: r = mk(OP_ADD, R_T, R_T, R_T);
      6'd50: r = mk(OP_MUL, R_RZ, R_S2, R_S);
      6'd51: r = mk(OP_ADD, R_RZ, R_RZ, R_RZ);
      6'd52: r = mk(OP_ADD, R_RZ, R_RZ, R_RZ);
      6'd53: r = mk(OP_ADD, R_RZ, R_RZ, R_RZ);
      6'd54: r = mk(OP_ADD, R_RY, R_B, R_B);
      6'd55: r = mk(OP_ADD, R_RY, R_RY, R_RY);
      6'd56: r = mk(OP_SUB, R_RY, R_RY, R_H);
      6'd57: r = mk(OP_MUL, R_RY, R_RY, R_W);
      6'd58: r = mk(OP_SUB, R_RY, R_RY, R_T);
      default: r = mk(OP_END, R_X1, R_X1, R_X1);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ec_projective_point_add_double.sv -----
// top level of the secp256k1 projective point add / double engine
//
// input stream: one 64-bit coordinate word per transfer, tagged in tuser with
// the command, the point, the coordinate and the word position; tlast on the
// final word starts the operation (add, or double of the first point)
// output stream: twelve result words, X words 0..3, then Y, then Z, with
// coordinate, word position and the infinity flag in tuser, tlast on the last
// loading: one word per cycle while idle; s_tready_o drops once tlast is taken
// operation: 6 coordinate loads, then the microcode; every field multiply
// runs on a shared bit-serial unit; an addition costs 14 multiplies, a
// doubling 11, infinity stops after 5, equal points run 5 then the 11 of
// the doubling
// the multiplier sets the rate; one operation is in flight at a time
// output: each coordinate is read and loaded into the output buffer, then its four words are held
// until m_tready_i takes them; a stalled receiver simply holds the engine
// reset: back to idle, ready for words; stored points are undefined until loaded
module ec_projective_point_add_double #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,   // in_word
  input  logic [7:0]  s_tuser_i,   // command, operand, in_coordinate[1:0], in_word_index[1:0], pad
  input  logic        s_tlast_i,   // last_word
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // out_word
  output logic [7:0]  m_tuser_o,   // out_coordinate[1:0], out_word_index[1:0], at_infinity, pad
  output logic        m_tlast_o    // last_result
);
  import ecpa_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] oc, oi;
  logic       inf;

  ecpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .command_i  (s_tuser_i[0]),
    .operand_i  (s_tuser_i[1]),
    .in_coord_i (s_tuser_i[3:2]),
    .in_idx_i   (s_tuser_i[5:4]),
    .s_tlast_i  (s_tlast_i),
    .s_tready_o (s_tready_o),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tlast_o  (m_tlast_o),
    .out_coord_o(oc),
    .out_idx_o  (oi),
    .inf_o      (inf),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath holds the operand words, register file and multiplier
  ecpa_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (s_tdata_i),
    .sts_o     (sts),
    .out_word_o(m_tdata_o)
  );

  assign m_tuser_o = {3'b000, inf, oi, oc};

endmodule

// ----- rtl/core/ecpa_modmul.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module ecpa_modmul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ecpa_pkg::fe_t     a_i,
  input  ecpa_pkg::fe_t     b_i,
  output logic              busy_o,
  output ecpa_pkg::fe_t     p_o
);
  import ecpa_pkg::*;

  logic          busy_q;
  logic [7:0]    cnt_q;
  fe_t           a_q, b_q, acc_q;
  logic [257:0]  t;
  logic [258:0]  t1, t2;
  fe_t           acc_d;

  always_comb begin
    t  = {acc_q, 1'b0} + (b_q[FE_BITS-1] ? {2'b00, a_q} : 258'd0);
    t1 = {1'b0, t} - {3'b000, PRIME};
    t2 = {1'b0, t} - {2'b00, PRIME, 1'b0};
    if (!t2[258]) begin
      acc_d = t2[FE_BITS-1:0];
    end else if (!t1[258]) begin
      acc_d = t1[FE_BITS-1:0];
    end else begin
      acc_d = t[FE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 8'hFF;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 8'd1;
      if (cnt_q == 8'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[FE_BITS-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign p_o    = acc_q;

endmodule

// ----- rtl/core/ecpa_datapath.sv -----
// datapath: operand word store, register file, field alu, multiplier, output buffer
module ecpa_datapath #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecpa_pkg::cmd_t cmd_i,
  input  logic [63:0]    in_word_i,
  output ecpa_pkg::sts_t sts_o,
  output logic [63:0]    out_word_o
);
  import ecpa_pkg::*;

  logic [WORD_BITS-1:0] ow_mem [24];
  logic [WORD_BITS-1:0] ow_rdata_q;
  fe_t                  rf_mem [32];
  fe_t                  rda_q, rdb_q;
  fe_t                  asm_q, out_q;
  fe_t                  alu_res, wb_data, ld_red, mul_p;
  logic [256:0]         sum, dif;
  logic [257:0]         sum_m;
  logic [256:0]         ld_m;
  logic                 eqv_q, equ_q, mul_busy;

  // operand word store
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_we) begin
      ow_mem[cmd_i.in_addr] <= in_word_i[WORD_BITS-1:0];
    end
    if (cmd_i.ow_rd) begin
      ow_rdata_q <= ow_mem[cmd_i.ow_addr];
    end
  end

  // coordinate assembly, word 0 ends in the low bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_shift) begin
      asm_q <= {64'(ow_rdata_q), asm_q[FE_BITS-1:64]};
    end
  end

  assign ld_m   = {1'b0, asm_q} - {1'b0, PRIME};
  assign ld_red = ld_m[256] ? asm_q : ld_m[FE_BITS-1:0];

  // field add / sub
  always_comb begin
    sum   = {1'b0, rda_q} + {1'b0, rdb_q};
    sum_m = {1'b0, sum} - {2'b00, PRIME};
    dif   = {1'b0, rda_q} - {1'b0, rdb_q};
    case (cmd_i.alu_op)
      OP_SUB:  alu_res = dif[256] ? (dif[FE_BITS-1:0] + PRIME) : dif[FE_BITS-1:0];
      default: alu_res = sum_m[257] ? sum[FE_BITS-1:0] : sum_m[FE_BITS-1:0];
    endcase
  end

  ecpa_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (rda_q),
    .b_i    (rdb_q),
    .busy_o (mul_busy),
    .p_o    (mul_p)
  );

  always_comb begin
    case (cmd_i.wb_sel)
      WB_MUL:  wb_data = mul_p;
      WB_LOAD: wb_data = ld_red;
      default: wb_data = alu_res;
    endcase
  end

  // register file, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      rf_mem[cmd_i.wb_dst] <= wb_data;
    end
    if (cmd_i.rf_rd) begin
      rda_q <= rf_mem[cmd_i.ra];
      rdb_q <= rf_mem[cmd_i.rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eqv_q <= 1'b0;
      equ_q <= 1'b0;
    end else begin
      if (cmd_i.cmpv_en) eqv_q <= (rda_q == rdb_q);
      if (cmd_i.cmpu_en) equ_q <= (rda_q == rdb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_zero ? '0 : rda_q;
    end else if (cmd_i.out_shift) begin
      out_q <= {64'd0, out_q[FE_BITS-1:64]};
    end
  end

  assign out_word_o     = 64'(out_q[WORD_BITS-1:0]);
  assign sts_o.mul_done = !mul_busy;
  assign sts_o.eq_v     = eqv_q;
  assign sts_o.eq_u     = equ_q;

endmodule

// ----- rtl/core/ecpa_ctrl.sv -----
// controller: input handshake, microcode sequencer, result word sequencing
module ecpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           command_i,
  input  logic           operand_i,
  input  logic [1:0]     in_coord_i,
  input  logic [1:0]     in_idx_i,
  input  logic           s_tlast_i,
  output logic           s_tready_o,
  input  logic           m_tready_i,
  output logic           m_tvalid_o,
  output logic           m_tlast_o,
  output logic [1:0]     out_coord_o,
  output logic [1:0]     out_idx_o,
  output logic           inf_o,
  output ecpa_pkg::cmd_t cmd_o,
  input  ecpa_pkg::sts_t sts_i
);
  import ecpa_pkg::*;

  state_e     state_q, state_d;
  pc_t        pc_q, pc_d;
  logic [2:0] ldcnt_q, ldcnt_d;
  logic       dbl_q, dbl_d, inf_q, inf_d;
  logic [1:0] oc_q, oc_d, oi_q, oi_d;
  instr_t     ir;
  logic       s_acc, m_acc;

  assign ir    = prog_rom(pc_q);
  assign s_acc = s_tvalid_i && (state_q == S_IDLE);
  assign m_acc = m_tready_i && (state_q == S_OUT);

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    ldcnt_d = ldcnt_q;
    dbl_d   = dbl_q;
    inf_d   = inf_q;
    oc_d    = oc_q;
    oi_d    = oi_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && s_tlast_i) begin
          dbl_d   = command_i;
          inf_d   = 1'b0;
          pc_d    = '0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (ir.op)
          OP_LOAD: begin
            ldcnt_d = '0;
            state_d = S_LOAD;
          end
          OP_BRANCH: begin
            if (sts_i.eq_v && !sts_i.eq_u) begin
              inf_d   = 1'b1;
              oc_d    = COORD_X;
              oi_d    = '0;
              state_d = S_OUTRD;
            end else if (sts_i.eq_v) begin
              pc_d = PC_DBL;
            end else begin
              pc_d = pc_q + 6'd1;
            end
          end
          OP_END: begin
            oc_d    = COORD_X;
            oi_d    = '0;
            state_d = S_OUTRD;
          end
          default: state_d = S_EXEC;
        endcase
      end
      S_EXEC: begin
        if (ir.op == OP_MUL) begin
          state_d = S_MUL;
        end else begin
          pc_d    = pc_q + 6'd1;
          state_d = S_FETCH;
        end
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          pc_d    = pc_q + 6'd1;
          state_d = S_FETCH;
        end
      end
      S_LOAD: begin
        ldcnt_d = ldcnt_q + 3'd1;
        if (ldcnt_q == 3'd5) begin
          if (pc_q == PC_LAST_LOAD) begin
            pc_d = dbl_q ? PC_DBL : PC_ADD;
          end else begin
            pc_d = pc_q + 6'd1;
          end
          state_d = S_FETCH;
        end
      end
      S_OUTRD: state_d = S_OUTLD;
      S_OUTLD: state_d = S_OUT;
      S_OUT: begin
        if (m_acc) begin
          oi_d = oi_q + 2'd1;
          if (oi_q == WORD_LAST) begin
            if (oc_q == COORD_Z) begin
              state_d = S_IDLE;
            end else begin
              oc_d    = oc_q + 2'd1;
              state_d = S_OUTRD;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.alu_op  = ir.op;
    cmd_o.wb_sel  = WB_ALU;
    cmd_o.wb_dst  = ir.dst;
    cmd_o.ra      = ir.src_a;
    cmd_o.rb      = ir.src_b;
    cmd_o.in_we   = s_acc && (in_coord_i != 2'd3);
    cmd_o.in_addr = (operand_i ? POINT2_BASE : 5'd0) + {1'b0, in_coord_i, in_idx_i};
    cmd_o.ow_addr = {ir.src_a[2:0], ldcnt_q[1:0]};
    cmd_o.out_zero = inf_q;
    unique case (state_q)
      S_FETCH: cmd_o.rf_rd = (ir.op != OP_LOAD) && (ir.op != OP_BRANCH) && (ir.op != OP_END);
      S_EXEC: begin
        cmd_o.mul_start = (ir.op == OP_MUL);
        cmd_o.wb_en     = (ir.op == OP_ADD) || (ir.op == OP_SUB);
        cmd_o.cmpv_en   = (ir.op == OP_CMPV);
        cmd_o.cmpu_en   = (ir.op == OP_CMPU);
      end
      S_MUL: begin
        cmd_o.wb_sel = WB_MUL;
        cmd_o.wb_en  = sts_i.mul_done;
      end
      S_LOAD: begin
        cmd_o.ow_rd    = (ldcnt_q < 3'd4);
        cmd_o.ld_shift = (ldcnt_q != 3'd0) && (ldcnt_q != 3'd5);
        cmd_o.wb_sel   = WB_LOAD;
        cmd_o.wb_en    = (ldcnt_q == 3'd5);
      end
      S_OUTRD: begin
        cmd_o.rf_rd = 1'b1;
        cmd_o.ra    = R_RX + {3'b000, oc_q};
      end
      S_OUTLD: cmd_o.out_load = 1'b1;
      S_OUT:   cmd_o.out_shift = m_acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      ldcnt_q <= '0;
      dbl_q   <= 1'b0;
      inf_q   <= 1'b0;
      oc_q    <= '0;
      oi_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ldcnt_q <= ldcnt_d;
      dbl_q   <= dbl_d;
      inf_q   <= inf_d;
      oc_q    <= oc_d;
      oi_q    <= oi_d;
    end
  end

  assign s_tready_o  = (state_q == S_IDLE);
  assign m_tvalid_o  = (state_q == S_OUT);
  assign m_tlast_o   = (oc_q == COORD_Z) && (oi_q == WORD_LAST);
  assign out_coord_o = oc_q;
  assign out_idx_o   = oi_q;
  assign inf_o       = inf_q;

endmodule

// ----- rtl/core/ecpa_checker.sv -----
// port-level checks for the point engine, bound to the top level
module ecpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [63:0] m_tdata_o,
  input logic [7:0]  m_tuser_o,
  input logic        m_tlast_o
);

  // no new words are taken while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o) else $error("input ready while result pending");

  // last word is Z word 3
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tlast_o) |-> (m_tuser_o[1:0] == 2'd2 && m_tuser_o[3:2] == 2'd3))
    else $error("tlast on wrong word");

  // infinity words are zero
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[4]) |-> (m_tdata_o == 64'd0))
    else $error("nonzero word at infinity");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("result word dropped while stalled");

endmodule

bind ec_projective_point_add_double ecpa_checker u_ecpa_checker (.*);

// ----- dv/tb_top.sv -----
// testbench for the secp256k1 projective point add / double engine
`timescale 1ns / 100ps

module tb_top;
  import ecpa_pkg::*;

  localparam int unsigned N_RANDOM = 300;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 3000;

  // one input word with its tags
  typedef struct packed {
    logic        cmd;
    logic        pt;
    logic [1:0]  crd;
    logic [1:0]  idx;
    logic [63:0] w;
    logic        last;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [1:0]  crd;
    logic [1:0]  idx;
    logic [63:0] w;
    logic        inf;
    logic        last;
  } res_word_t;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DBL = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [63:0] s_tdata_i = '0;
  logic [7:0]  s_tuser_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [63:0] m_tdata_o;
  logic [7:0]  m_tuser_o;
  logic        m_tlast_o;

  ec_projective_point_add_double dut (.*);

  always #6 clk_i = ~clk_i;

  in_word_t  pending_words[$];
  res_word_t expected_words[$];
  logic [63:0] gen_words[24];   // what the stimulus side has queued so far
  logic [63:0] point_words[24]; // loaded words as the engine sees them
  int unsigned n_errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // ---------------- field arithmetic ----------------
  function automatic fe_t f_mul(fe_t a, fe_t b);
    logic [511:0] p;
    p = {256'b0, a} * {256'b0, b};
    return fe_t'(p % {256'b0, PRIME});
  endfunction

  function automatic fe_t f_add(fe_t a, fe_t b);
    logic [256:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[255:0];
  endfunction

  function automatic fe_t f_sub(fe_t a, fe_t b);
    if (a >= b) return a - b;
    return fe_t'({1'b0, a} + {1'b0, PRIME} - {1'b0, b});
  endfunction

  function automatic fe_t coord_of(int pt, int c);
    fe_t v;
    for (int i = 0; i < 4; i++) v[64*i +: 64] = point_words[pt*12 + c*4 + i];
    if (v >= PRIME) v = v - PRIME;
    return v;
  endfunction

  task automatic point_double(input fe_t x, input fe_t y, input fe_t z,
                              output fe_t rx, output fe_t ry, output fe_t rz);
    fe_t t, w, s, b, h, b8, s2, yy;
    t = f_mul(x, x);
    w = f_add(f_add(t, t), t);
    s = f_mul(y, z);
    b = f_mul(f_mul(y, s), x);
    h = f_mul(w, w);
    b8 = f_add(b, b);
    b8 = f_add(b8, b8);
    b8 = f_add(b8, b8);
    h = f_sub(h, b8);
    rx = f_mul(h, s);
    rx = f_add(rx, rx);
    s2 = f_mul(s, s);
    yy = f_mul(y, y);
    t = f_mul(yy, s2);
    t = f_add(t, t);
    t = f_add(t, t);
    t = f_add(t, t);
    rz = f_mul(s2, s);
    rz = f_add(rz, rz);
    rz = f_add(rz, rz);
    rz = f_add(rz, rz);
    ry = f_add(b, b);
    ry = f_add(ry, ry);
    ry = f_sub(ry, h);
    ry = f_mul(ry, w);
    ry = f_sub(ry, t);
  endtask

  // works out the twelve result words of one operation
  task automatic predict_point_op(input logic cmd);
    fe_t x1, y1, z1, x2, y2, z2, rx, ry, rz;
    fe_t u1, u2, u, v1, v2, v, ww, us2w, vs2, vs3, vs2v2, a;
    fe_t res[3];
    logic inf;
    res_word_t r;
    x1 = coord_of(0, 0); y1 = coord_of(0, 1); z1 = coord_of(0, 2);
    x2 = coord_of(1, 0); y2 = coord_of(1, 1); z2 = coord_of(1, 2);
    inf = 1'b0;
    if (cmd == CMD_DBL) begin
      point_double(x1, y1, z1, rx, ry, rz);
    end else begin
      u1 = f_mul(y2, z1);
      u2 = f_mul(y1, z2);
      u = f_sub(u1, u2);
      v1 = f_mul(x2, z1);
      v2 = f_mul(x1, z2);
      v = f_sub(v1, v2);
      ww = f_mul(z1, z2);
      if (v1 == v2) begin
        if (u1 != u2) begin
          // same x, opposite y: point at infinity
          inf = 1'b1;
          rx = '0; ry = '0; rz = '0;
        end else begin
          point_double(x1, y1, z1, rx, ry, rz);
        end
      end else begin
        us2w = f_mul(f_mul(u, u), ww);
        vs2 = f_mul(v, v);
        vs3 = f_mul(vs2, v);
        vs2v2 = f_mul(vs2, v2);
        a = f_sub(f_sub(f_sub(us2w, vs3), vs2v2), vs2v2);
        rx = f_mul(v, a);
        rz = f_mul(vs3, ww);
        vs3 = f_mul(vs3, u2);
        ry = f_mul(f_sub(vs2v2, a), u);
        ry = f_sub(ry, vs3);
      end
    end
    res[0] = rx; res[1] = ry; res[2] = rz;
    for (int k = 0; k < 12; k++) begin
      r.crd = 2'(k / 4);
      r.idx = 2'(k % 4);
      r.w = res[k/4][64*(k%4) +: 64];
      r.inf = inf;
      r.last = (k == 11);
      expected_words.push_back(r);
    end
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_word(logic cmd, logic pt, logic [1:0] crd, logic [1:0] idx,
                            logic [63:0] w, logic last);
    pending_words.push_back('{cmd, pt, crd, idx, w, last});
    if (crd != WORD_LAST) gen_words[pt*12 + crd*4 + idx] = w;
  endtask

  // copy point 1 into point 2, optionally altering y, then start an addition
  task automatic queue_copy_add(bit alter_y);
    logic [63:0] w;
    for (int k = 0; k < 12; k++) begin
      w = gen_words[k];
      if (alter_y && k == 4) w = w ^ 64'h1;
      queue_word(CMD_ADD, 1'b1, 2'(k / 4), 2'(k % 4), w, k == 11);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result word %0d: %s got %h expected %h",
             n_results, what, got, want);
    n_errors++;
  endtask

  // ---------------- input driver ----------------
  function automatic int unsigned sender_idle_pct();
    if (n_accepted < 100) return 0;
    if (n_accepted < 200) return 52;
    if (n_accepted < 300) return 0;
    return 17;
  endfunction

  always @(posedge clk_i) begin
    in_word_t nxt;
    if (rst_ni && (!s_tvalid_i || s_tready_o)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        nxt = pending_words.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i <= nxt.w;
        s_tuser_i <= {2'b00, nxt.idx, nxt.crd, nxt.pt, nxt.cmd};
        s_tlast_i <= nxt.last;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // input monitor feeds the predictor with every accepted word
  always @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      n_accepted++;
      if (s_tuser_i[3:2] != WORD_LAST)
        point_words[s_tuser_i[1]*12 + s_tuser_i[3:2]*4 + s_tuser_i[5:4]] = s_tdata_i;
      if (s_tlast_i) predict_point_op(s_tuser_i[0]);
    end
  end

  // ---------------- output side ----------------
  function automatic int unsigned recv_stall_pct();
    if (n_accepted < 200) return 0;
    if (n_accepted < 300) return 52;
    return 17;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready_i <= 1'b0;
      end else if (!hold_done && n_results >= 24) begin
        // long hold-off so the engine backs up and stalls its input
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= ($urandom_range(99) >= recv_stall_pct());
      end
    end
  end

  always @(posedge clk_i) begin
    res_word_t e;
    if (m_tvalid_o && m_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_tdata_o, '0);
      end else begin
        e = expected_words.pop_front();
        if (m_tuser_o[1:0] != e.crd)
          report_mismatch("coordinate", 64'(m_tuser_o[1:0]), 64'(e.crd));
        if (m_tuser_o[3:2] != e.idx)
          report_mismatch("word index", 64'(m_tuser_o[3:2]), 64'(e.idx));
        if (m_tdata_o != e.w) report_mismatch("data", m_tdata_o, e.w);
        if (m_tuser_o[4] != e.inf)
          report_mismatch("infinity flag", 64'(m_tuser_o[4]), 64'(e.inf));
        if (m_tlast_o != e.last)
          report_mismatch("tlast", 64'(m_tlast_o), 64'(e.last));
      end
      n_results++;
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int unsigned k, n;
    // directed: full load, extremes, x coordinate not below the prime
    for (int i = 0; i < 24; i++) begin
      case (i)
        0, 1, 2, 3: queue_word(CMD_ADD, 1'(i / 12), 2'((i % 12) / 4), 2'(i % 4), '1, 1'b0);
        13: queue_word(CMD_ADD, 1'b1, COORD_X, 2'd1, '0, 1'b0);
        default: queue_word(CMD_ADD, 1'(i / 12), 2'((i % 12) / 4), 2'(i % 4),
                            {$urandom, $urandom}, i == 23);
      endcase
    end
    // doubling, and an unused coordinate code that still starts the operation
    queue_word(CMD_DBL, 1'b0, COORD_Z, 2'd3, {$urandom, $urandom}, 1'b1);
    queue_word(CMD_DBL, 1'b1, WORD_LAST, 2'd2, '1, 1'b0);
    queue_word(CMD_ADD, 1'b1, WORD_LAST, 2'd3, '1, 1'b1);
    // same point twice falls back to doubling, then an altered y gives infinity
    queue_copy_add(1'b0);
    queue_copy_add(1'b1);
    // zero y doubles to zero X and Z coordinates
    for (int i = 0; i < 4; i++)
      queue_word(CMD_DBL, 1'b0, COORD_Y, 2'(i), '0, i == 3);

    // random sequences of word updates, most ending in a start
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(9))
        0: begin
          k = $urandom_range(1, 5);
          repeat (k) queue_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                                2'($urandom_range(3)), 2'($urandom_range(3)),
                                rand_word(), 1'b0);
          n += k;
        end
        1: begin queue_copy_add(1'b1); n += 12; end
        2: begin queue_copy_add(1'b0); n += 12; end
        default: begin
          k = $urandom_range(1, 8);
          for (int i = 0; i < k; i++)
            queue_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                       ($urandom_range(15) == 0) ? WORD_LAST : 2'($urandom_range(2)),
                       2'($urandom_range(3)), rand_word(), i == k - 1);
          n += k;
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !s_tvalid_i);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ecpa_pkg.sv
rtl/core/ecpa_modmul.sv
rtl/core/ecpa_datapath.sv
rtl/core/ecpa_ctrl.sv
rtl/core/ec_projective_point_add_double.sv
rtl/core/ecpa_checker.sv
dv/tb_top.sv
